// File: design/vlos_pkg.sv
package vlos_pkg;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_TRACE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		CFG_MAP_WIDTH  = 2'd0,
		CFG_MAP_HEIGHT = 2'd1,
		CFG_MAP_DEPTH  = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_WALK
	} back_state_t;

	localparam logic [6:0] MAP_WIDTH_RST  = 7'd64;
	localparam logic [6:0] MAP_HEIGHT_RST = 7'd64;
	localparam logic [3:0] MAP_DEPTH_RST  = 4'd8;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		opcode_t            op;
		logic [5:0]         sx;
		logic [5:0]         sy;
		logic [2:0]         sz;
		logic [5:0]         ex;
		logic [5:0]         ey;
		logic [2:0]         ez;
		logic               blocks;
		axis_t              axis;
		logic               dir_x;
		logic               dir_y;
		logic               dir_z;
		logic signed [8:0]  err1;
		logic signed [8:0]  err2;
		logic [7:0]         two_da;
		logic [7:0]         two_d1;
		logic [7:0]         two_d2;
		logic [6:0]         steps;
	} cmd_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

endpackage

// File: design/vlos_queue.sv
module vlos_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vlos_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output vlos_pkg::cmd_t pop_data
);
	import vlos_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: design/vlos_front.sv
module vlos_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   opcode,
	input  logic [5:0]             start_x,
	input  logic [5:0]             start_y,
	input  logic [2:0]             start_z,
	input  logic [5:0]             end_x,
	input  logic [5:0]             end_y,
	input  logic [2:0]             end_z,
	input  logic                   tile_blocks,
	input  vlos_pkg::back_status_t status,
	input  logic                   q_full,
	output logic                   push,
	output vlos_pkg::cmd_t         push_data
);
	import vlos_pkg::*;

	logic       valid_s1_q;
	opcode_t    op_s1;
	logic [5:0] sx_s1;
	logic [5:0] sy_s1;
	logic [2:0] sz_s1;
	logic [5:0] ex_s1;
	logic [5:0] ey_s1;
	logic [2:0] ez_s1;
	logic       blocks_s1;
	logic       accept;

	assign busy   = status.clearing | (valid_s1_q & q_full);
	assign accept = start & ~busy;
	assign push   = valid_s1_q & ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (accept) begin
			valid_s1_q <= 1'b1;
		end else if (push) begin
			valid_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= opcode_t'(opcode);
			sx_s1     <= start_x;
			sy_s1     <= start_y;
			sz_s1     <= start_z;
			ex_s1     <= end_x;
			ey_s1     <= end_y;
			ez_s1     <= end_z;
			blocks_s1 <= tile_blocks;
		end
	end

	always_comb begin
		logic [5:0] dx;
		logic [5:0] dy;
		logic [5:0] dz;
		logic [5:0] da;
		logic [5:0] dm1;
		logic [5:0] dm2;
		axis_t      axis;

		dx = (sx_s1 > ex_s1) ? sx_s1 - ex_s1 : ex_s1 - sx_s1;
		dy = (sy_s1 > ey_s1) ? sy_s1 - ey_s1 : ey_s1 - sy_s1;
		dz = {3'b000, (sz_s1 > ez_s1) ? sz_s1 - ez_s1 : ez_s1 - sz_s1};

		if (dx >= dy && dx >= dz) begin
			axis = AXIS_X;
		end else if (dy >= dz) begin
			axis = AXIS_Y;
		end else begin
			axis = AXIS_Z;
		end

		case (axis)
			AXIS_X: begin
				da  = dx;
				dm1 = dy;
				dm2 = dz;
			end
			AXIS_Y: begin
				da  = dy;
				dm1 = dx;
				dm2 = dz;
			end
			default: begin
				da  = dz;
				dm1 = dx;
				dm2 = dy;
			end
		endcase

		push_data.op     = op_s1;
		push_data.sx     = sx_s1;
		push_data.sy     = sy_s1;
		push_data.sz     = sz_s1;
		push_data.ex     = ex_s1;
		push_data.ey     = ey_s1;
		push_data.ez     = ez_s1;
		push_data.blocks = blocks_s1;
		push_data.axis   = axis;
		push_data.dir_x  = (sx_s1 < ex_s1);
		push_data.dir_y  = (sy_s1 < ey_s1);
		push_data.dir_z  = (sz_s1 < ez_s1);
		push_data.err1   = $signed({2'b00, dm1, 1'b0}) - $signed({3'b000, da});
		push_data.err2   = $signed({2'b00, dm2, 1'b0}) - $signed({3'b000, da});
		push_data.two_da = {1'b0, da, 1'b0};
		push_data.two_d1 = {1'b0, dm1, 1'b0};
		push_data.two_d2 = {1'b0, dm2, 1'b0};
		push_data.steps  = {1'b0, da} + 7'd1;
	end

endmodule

// File: design/vlos_back.sv
module vlos_back #(
	parameter int MAX_X = 64,
	parameter int MAX_Y = 64,
	parameter int MAX_Z = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  vlos_pkg::cmd_t         q_data,
	output logic                   q_pop,
	input  logic [6:0]             map_width,
	input  logic [6:0]             map_height,
	input  logic [3:0]             map_depth,
	output vlos_pkg::back_status_t status,
	output logic                   result_valid,
	output logic [5:0]             point_x,
	output logic [5:0]             point_y,
	output logic [2:0]             point_z,
	output logic                   last_point,
	output logic                   blocker_here,
	output logic                   visible
);
	import vlos_pkg::*;

	localparam int DEPTH  = MAX_X * MAX_Y * MAX_Z;
	localparam int ADDR_W = $clog2(DEPTH);

	back_state_t       state_q;
	back_state_t       state_d;
	logic [ADDR_W-1:0] clr_cnt_q;
	cmd_t              cmd_q;
	logic [5:0]        cur_x_q;
	logic [5:0]        cur_y_q;
	logic [2:0]        cur_z_q;
	logic signed [8:0] e1_q;
	logic signed [8:0] e2_q;
	logic [6:0]        steps_q;
	logic              first_q;

	logic              mem [DEPTH];
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic              mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic              load_walk;
	logic              walk_step;

	logic              pt_valid_s2;
	logic [5:0]        pt_x_s2;
	logic [5:0]        pt_y_s2;
	logic [2:0]        pt_z_s2;
	logic              last_s2;
	logic              first_s2;
	logic              at_end_s2;
	logic              in_map_s2;
	logic              mem_bit_s2;

	logic              decided_q;
	logic              out_valid_q;
	logic [5:0]        out_x_q;
	logic [5:0]        out_y_q;
	logic [2:0]        out_z_q;
	logic              out_last_q;
	logic              out_blocker_q;
	logic              out_visible_q;

	logic              cur_in_store;
	logic              cur_in_map;
	logic [5:0]        nxt_x;
	logic [5:0]        nxt_y;
	logic [2:0]        nxt_z;
	logic signed [8:0] nxt_e1;
	logic signed [8:0] nxt_e2;

	logic              dec_prev;
	logic              test;
	logic              hit;
	logic              blk;
	logic              vis;

	function automatic logic store_holds(input logic [5:0] x, input logic [5:0] y,
			input logic [2:0] z);
		store_holds = (int'(x) < MAX_X) && (int'(y) < MAX_Y) && (int'(z) < MAX_Z);
	endfunction

	function automatic logic [ADDR_W-1:0] vox_index(input logic [5:0] x, input logic [5:0] y,
			input logic [2:0] z);
		vox_index = ADDR_W'((int'(z) * MAX_Y + int'(y)) * MAX_X + int'(x));
	endfunction

	assign status.clearing = (state_q == BK_CLEAR);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_CLEAR: begin
				if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (q_valid && q_data.op == OP_TRACE) begin
					state_d = BK_WALK;
				end
			end
			BK_WALK: begin
				if (steps_q == 7'd1) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = clr_cnt_q;
		mem_wdata = 1'b0;
		load_walk = 1'b0;
		walk_step = 1'b0;
		case (state_q)
			BK_CLEAR: begin
				mem_we = 1'b1;
			end
			BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_data.op == OP_WRITE) begin
						mem_we    = store_holds(q_data.sx, q_data.sy, q_data.sz);
						mem_waddr = vox_index(q_data.sx, q_data.sy, q_data.sz);
						mem_wdata = q_data.blocks;
					end else begin
						load_walk = 1'b1;
					end
				end
			end
			BK_WALK: begin
				walk_step = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		logic inc1;
		logic inc2;
		logic step_x;
		logic step_y;
		logic step_z;

		inc1 = ~e1_q[8];
		inc2 = ~e2_q[8];
		case (cmd_q.axis)
			AXIS_X: begin
				step_x = 1'b1;
				step_y = inc1;
				step_z = inc2;
			end
			AXIS_Y: begin
				step_x = inc1;
				step_y = 1'b1;
				step_z = inc2;
			end
			default: begin
				step_x = inc1;
				step_y = inc2;
				step_z = 1'b1;
			end
		endcase

		nxt_x = step_x ? (cmd_q.dir_x ? cur_x_q + 6'd1 : cur_x_q - 6'd1) : cur_x_q;
		nxt_y = step_y ? (cmd_q.dir_y ? cur_y_q + 6'd1 : cur_y_q - 6'd1) : cur_y_q;
		nxt_z = step_z ? (cmd_q.dir_z ? cur_z_q + 3'd1 : cur_z_q - 3'd1) : cur_z_q;

		nxt_e1 = (inc1 ? e1_q - $signed({1'b0, cmd_q.two_da}) : e1_q)
			+ $signed({1'b0, cmd_q.two_d1});
		nxt_e2 = (inc2 ? e2_q - $signed({1'b0, cmd_q.two_da}) : e2_q)
			+ $signed({1'b0, cmd_q.two_d2});
	end

	assign cur_in_store = store_holds(cur_x_q, cur_y_q, cur_z_q);
	assign cur_in_map   = cur_in_store && ({1'b0, cur_x_q} < map_width)
		&& ({1'b0, cur_y_q} < map_height) && ({1'b0, cur_z_q} < map_depth);
	assign mem_raddr    = cur_in_store ? vox_index(cur_x_q, cur_y_q, cur_z_q) : '0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_bit_s2 <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_cnt_q   <= '0;
			steps_q     <= '0;
			first_q     <= 1'b0;
			pt_valid_s2 <= 1'b0;
			decided_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			end
			if (load_walk) begin
				steps_q <= q_data.steps;
				first_q <= 1'b1;
			end else if (walk_step) begin
				steps_q <= steps_q - 7'd1;
				first_q <= 1'b0;
			end
			pt_valid_s2 <= walk_step;
			if (pt_valid_s2) begin
				decided_q <= dec_prev | hit;
			end
			out_valid_q <= pt_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load_walk) begin
			cmd_q   <= q_data;
			cur_x_q <= q_data.sx;
			cur_y_q <= q_data.sy;
			cur_z_q <= q_data.sz;
			e1_q    <= q_data.err1;
			e2_q    <= q_data.err2;
		end else if (walk_step) begin
			cur_x_q <= nxt_x;
			cur_y_q <= nxt_y;
			cur_z_q <= nxt_z;
			e1_q    <= nxt_e1;
			e2_q    <= nxt_e2;
		end
		pt_x_s2   <= cur_x_q;
		pt_y_s2   <= cur_y_q;
		pt_z_s2   <= cur_z_q;
		last_s2   <= (steps_q == 7'd1);
		first_s2  <= first_q;
		at_end_s2 <= (cur_x_q == cmd_q.ex) && (cur_y_q == cmd_q.ey) && (cur_z_q == cmd_q.ez);
		in_map_s2 <= cur_in_map;
	end

	// The start point is never tested; after that, the first point that leaves the
	// map, reaches the end or hits a blocking voxel settles the sight question.
	assign dec_prev = first_s2 ? 1'b0 : decided_q;
	assign test     = ~first_s2 & ~dec_prev;
	assign hit      = test & (~in_map_s2 | at_end_s2 | mem_bit_s2);
	assign blk      = test & (~in_map_s2 | (~at_end_s2 & mem_bit_s2));
	assign vis      = last_s2 & ((test & in_map_s2 & at_end_s2) | ~(dec_prev | hit));

	always_ff @(posedge clk) begin
		out_x_q       <= pt_x_s2;
		out_y_q       <= pt_y_s2;
		out_z_q       <= pt_z_s2;
		out_last_q    <= last_s2;
		out_blocker_q <= blk;
		out_visible_q <= vis;
	end

	assign result_valid = out_valid_q;
	assign point_x      = out_x_q;
	assign point_y      = out_y_q;
	assign point_z      = out_z_q;
	assign last_point   = out_last_q;
	assign blocker_here = out_blocker_q;
	assign visible      = out_visible_q;

	a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_CLEAR) |-> !q_pop)
		else $error("An item was taken from the queue during the clearing pass.");

	a_walk_ends_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_WALK && steps_q == 7'd1) |=> (state_q == BK_IDLE))
		else $error("The walk did not stop after its last point.");

	a_start_never_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(pt_valid_s2 && first_s2) |=> (out_valid_q && !out_blocker_q))
		else $error("The start point of a trace was flagged as the blocker.");

	a_visible_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_visible_q) |-> (out_last_q && !out_blocker_q))
		else $error("Visibility was reported on a point that is not the clear last point.");

	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q != BK_WALK))
		else $error("The map was written while a trace was walking.");

endmodule

// File: design/voxel_line_of_sight_tracer.sv
// After reset the block sweeps the whole blocking map clear, one voxel per cycle;
// busy stays high until that pass is over, though configuration writes are taken
// throughout. An item is taken when start is high and busy is low; a short queue
// sits between the input stage and the walker, so several items can be taken while
// a trace runs. A write item is done from the walker's idle state and gives no
// results. A trace whose longest axis spans d voxels gives d + 1 points, one per
// cycle, and the walker returns to idle before the next item; the walker that steps
// the line one voxel at a time and the single read port of the map set that rate.
// If the walker is free, an item passes the input register, the queue, the walker
// registers, the map read and the output registers before its first point leaves
// the block. Each point is shown for one cycle with result_valid high and cannot be
// held off, so the receiver must take every point as it comes.
module voxel_line_of_sight_tracer #(
	parameter int MAX_X = 64,
	parameter int MAX_Y = 64,
	parameter int MAX_Z = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       opcode,
	input  logic [5:0] start_x,
	input  logic [5:0] start_y,
	input  logic [2:0] start_z,
	input  logic [5:0] end_x,
	input  logic [5:0] end_y,
	input  logic [2:0] end_z,
	input  logic       tile_blocks,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data,
	output logic       result_valid,
	output logic [5:0] point_x,
	output logic [5:0] point_y,
	output logic [2:0] point_z,
	output logic       last_point,
	output logic       blocker_here,
	output logic       visible
);
	import vlos_pkg::*;

	logic [6:0]   map_width_q;
	logic [6:0]   map_height_q;
	logic [3:0]   map_depth_q;
	back_status_t status;
	logic         q_full;
	logic         q_push;
	cmd_t         q_push_data;
	logic         q_pop;
	logic         q_valid;
	cmd_t         q_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= MAP_WIDTH_RST;
			map_height_q <= MAP_HEIGHT_RST;
			map_depth_q  <= MAP_DEPTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAP_WIDTH: begin
					map_width_q <= cfg_data;
				end
				CFG_MAP_HEIGHT: begin
					map_height_q <= cfg_data;
				end
				CFG_MAP_DEPTH: begin
					map_depth_q <= cfg_data[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	vlos_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.start_x     (start_x),
		.start_y     (start_y),
		.start_z     (start_z),
		.end_x       (end_x),
		.end_y       (end_y),
		.end_z       (end_z),
		.tile_blocks (tile_blocks),
		.status      (status),
		.q_full      (q_full),
		.push        (q_push),
		.push_data   (q_push_data)
	);

	vlos_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_data)
	);

	vlos_back #(
		.MAX_X (MAX_X),
		.MAX_Y (MAX_Y),
		.MAX_Z (MAX_Z)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.map_width    (map_width_q),
		.map_height   (map_height_q),
		.map_depth    (map_depth_q),
		.status       (status),
		.result_valid (result_valid),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.last_point   (last_point),
		.blocker_here (blocker_here),
		.visible      (visible)
	);

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
	import vlos_pkg::*;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_GAP       = 40;
	localparam int MAX_PRINTS    = 40;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 67;
	localparam int ROW_STRIDE    = 64;
	localparam int LEVEL_STRIDE  = 4096;
	localparam logic [1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [5:0] x;
		logic [5:0] y;
		logic [2:0] z;
		logic       last;
		logic       blocker;
		logic       seen;
	} point_t;

	class path_tracker;
		bit         opaque_voxel [0:32767];
		logic [6:0] width_reg;
		logic [6:0] height_reg;
		logic [3:0] depth_reg;
		point_t     due_points [$];
		int         fault_count;

		function new();
			width_reg = MAP_WIDTH_RST;
			height_reg = MAP_HEIGHT_RST;
			depth_reg = MAP_DEPTH_RST;
			fault_count = 0;
			foreach (opaque_voxel[i])
				opaque_voxel[i] = 1'b0;
		endfunction

		function void note_point(point_t p);
			due_points.insert(due_points.size(), p);
		endfunction

		function void take_config(logic [1:0] idx, logic [6:0] data);
			case (idx)
				CFG_MAP_WIDTH: begin
					width_reg = data;
				end
				CFG_MAP_HEIGHT: begin
					height_reg = data;
				end
				CFG_MAP_DEPTH: begin
					depth_reg = data[3:0];
				end
				default: begin
				end
			endcase
		endfunction

		function void take_item(opcode_t op, logic [5:0] sx, logic [5:0] sy, logic [2:0] sz,
				logic [5:0] ex, logic [5:0] ey, logic [2:0] ez, logic blocks);
			int pos [3];
			int goal [3];
			int span [3];
			int dir [3];
			int lead, s1, s2, e1, e2, a, k;
			bit settled, seen, stop, last;
			if (op == OP_WRITE) begin
				opaque_voxel[{sz, sy, sx}] = blocks;
				return;
			end
			pos = '{sx, sy, sz};
			goal = '{ex, ey, ez};
			for (a = 0; a < 3; a++) begin
				span[a] = goal[a] > pos[a] ? goal[a] - pos[a] : pos[a] - goal[a];
				dir[a] = pos[a] < goal[a] ? 1 : -1;
			end
			if (span[0] >= span[1] && span[0] >= span[2]) begin
				lead = 0; s1 = 1; s2 = 2;
			end else if (span[1] >= span[2]) begin
				lead = 1; s1 = 0; s2 = 2;
			end else begin
				lead = 2; s1 = 0; s2 = 1;
			end
			if (span[lead] == 0) begin
				note_point('{6'(pos[0]), 6'(pos[1]), 3'(pos[2]), 1'b1, 1'b0, 1'b1});
				return;
			end
			e1 = 2 * span[s1] - span[lead];
			e2 = 2 * span[s2] - span[lead];
			settled = 1'b0;
			seen = 1'b0;
			for (k = 0; k <= span[lead]; k++) begin
				stop = 1'b0;
				last = (k == span[lead]);
				if (k > 0 && !settled) begin
					if (pos[0] >= int'(width_reg) || pos[1] >= int'(height_reg) ||
							pos[2] >= int'(depth_reg)) begin
						stop = 1'b1;
						settled = 1'b1;
					end else if (pos[0] == goal[0] && pos[1] == goal[1] &&
							pos[2] == goal[2]) begin
						seen = 1'b1;
						settled = 1'b1;
					end else if (opaque_voxel[pos[2] * LEVEL_STRIDE + pos[1] * ROW_STRIDE + pos[0]]) begin
						stop = 1'b1;
						settled = 1'b1;
					end
				end
				if (last && !settled) begin
					seen = 1'b1;
					settled = 1'b1;
				end
				note_point('{6'(pos[0]), 6'(pos[1]), 3'(pos[2]), last, stop,
					last && seen});
				if (e1 >= 0) begin
					pos[s1] += dir[s1];
					e1 -= 2 * span[lead];
				end
				if (e2 >= 0) begin
					pos[s2] += dir[s2];
					e2 -= 2 * span[lead];
				end
				pos[lead] += dir[lead];
				e1 += 2 * span[s1];
				e2 += 2 * span[s2];
			end
		endfunction

		task report_fault(string what);
			if (fault_count < MAX_PRINTS)
				$display("%0t ns: %s", $time, what);
			fault_count++;
		endtask

		task take_point(logic [5:0] x, logic [5:0] y, logic [2:0] z, logic last,
				logic blocker, logic seen);
			point_t want;
			if (due_points.size() == 0) begin
				report_fault($sformatf("point (%0d,%0d,%0d) with no trace item waiting", x, y, z));
				return;
			end
			want = due_points.pop_front();
			if (x !== want.x)
				report_fault($sformatf("point_x %0d, expected %0d", x, want.x));
			if (y !== want.y)
				report_fault($sformatf("point_y %0d, expected %0d", y, want.y));
			if (z !== want.z)
				report_fault($sformatf("point_z %0d, expected %0d", z, want.z));
			if (last !== want.last)
				report_fault($sformatf("last_point %b, expected %b", last, want.last));
			if (blocker !== want.blocker)
				report_fault($sformatf("blocker_here %b, expected %b at (%0d,%0d,%0d)",
					blocker, want.blocker, want.x, want.y, want.z));
			if (seen !== want.seen)
				report_fault($sformatf("visible %b, expected %b at (%0d,%0d,%0d)",
					seen, want.seen, want.x, want.y, want.z));
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       opcode;
	logic [5:0] start_x;
	logic [5:0] start_y;
	logic [2:0] start_z;
	logic [5:0] end_x;
	logic [5:0] end_y;
	logic [2:0] end_z;
	logic       tile_blocks;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [6:0] cfg_data;
	logic       result_valid;
	logic [5:0] point_x;
	logic [5:0] point_y;
	logic [2:0] point_z;
	logic       last_point;
	logic       blocker_here;
	logic       visible;

	path_tracker tracker = new();
	int          idle_pct = 0;
	int          cycles = 0;

	voxel_line_of_sight_tracer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.start_x      (start_x),
		.start_y      (start_y),
		.start_z      (start_z),
		.end_x        (end_x),
		.end_y        (end_y),
		.end_z        (end_z),
		.tile_blocks  (tile_blocks),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.last_point   (last_point),
		.blocker_here (blocker_here),
		.visible      (visible)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("voxel_line_of_sight_tracer: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				tracker.take_point(point_x, point_y, point_z, last_point, blocker_here, visible);
			if (start && !busy)
				tracker.take_item(opcode_t'(opcode), start_x, start_y, start_z,
					end_x, end_y, end_z, tile_blocks);
			if (cfg_valid && cfg_ready)
				tracker.take_config(cfg_index, cfg_data);
		end
	end

	task automatic send_item(opcode_t op, logic [5:0] sx, logic [5:0] sy, logic [2:0] sz,
			logic [5:0] ex, logic [5:0] ey, logic [2:0] ez, logic blocks);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		start_x <= sx;
		start_y <= sy;
		start_z <= sz;
		end_x <= ex;
		end_y <= ey;
		end_z <= ez;
		tile_blocks <= blocks;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic trace(logic [5:0] sx, logic [5:0] sy, logic [2:0] sz,
			logic [5:0] ex, logic [5:0] ey, logic [2:0] ez);
		send_item(OP_TRACE, sx, sy, sz, ex, ey, ez, 1'($urandom_range(1)));
	endtask

	task automatic put_voxel(logic [5:0] x, logic [5:0] y, logic [2:0] z, logic blocks);
		send_item(OP_WRITE, x, y, z, 6'($urandom), 6'($urandom), 3'($urandom), blocks);
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (tracker.due_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_map(logic [6:0] w, logic [6:0] h, logic [6:0] d);
		logic [1:0] idx [4];
		logic [6:0] val [4];
		idx = '{CFG_MAP_WIDTH, CFG_MAP_HEIGHT, CFG_MAP_DEPTH, CFG_SPARE};
		val[0] = w;
		val[1] = h;
		val[2] = d;
		val[3] = 7'($urandom_range(127));
		cfg_valid <= 1'b1;
		foreach (idx[i]) begin
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item();
		int kind;
		logic [5:0] bx, by, px, py;
		logic [2:0] bz, pz;
		kind = $urandom_range(99);
		bx = $urandom_range(1) ? 6'd0 : 6'd52;
		by = $urandom_range(1) ? 6'd0 : 6'd52;
		bz = $urandom_range(1) ? 3'd0 : 3'd4;
		px = 6'($urandom);
		py = 6'($urandom);
		pz = 3'($urandom);
		if (kind < 25)
			put_voxel(bx + 6'($urandom_range(11)), by + 6'($urandom_range(11)),
				bz + 3'($urandom_range(3)), $urandom_range(99) < 75);
		else if (kind < 30)
			put_voxel(px, py, pz, 1'($urandom_range(1)));
		else if (kind < 80)
			trace(bx + 6'($urandom_range(11)), by + 6'($urandom_range(11)),
				bz + 3'($urandom_range(3)), bx + 6'($urandom_range(11)),
				by + 6'($urandom_range(11)), bz + 3'($urandom_range(3)));
		else if (kind < 85)
			trace(px, py, pz, px, py, pz);
		else
			trace(px, py, pz, 6'($urandom), 6'($urandom), 3'($urandom));
	endtask

	logic [6:0] phase_w [PHASES] = '{7'd64, 7'd127, 7'd12, 7'd1, 7'd0, 7'd64};
	logic [6:0] phase_h [PHASES] = '{7'd64, 7'd127, 7'd9, 7'd64, 7'd0, 7'd64};
	logic [6:0] phase_d [PHASES] = '{7'd8, 7'h7F, 7'd3, 7'd1, 7'd0, 7'd8};
	int         phase_idle [PHASES] = '{0, 81, 0, 19, 81, 19};

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		opcode <= OP_WRITE;
		start_x <= '0;
		start_y <= '0;
		start_z <= '0;
		end_x <= '0;
		end_y <= '0;
		end_z <= '0;
		tile_blocks <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_MAP_WIDTH;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// The first item is held off until the map has been swept clear.
		program_map(7'd64, 7'd64, 7'd8);
		trace(0, 0, 0, 0, 0, 0);
		trace(0, 0, 0, 63, 63, 7);
		trace(63, 63, 7, 0, 0, 0);
		trace(5, 0, 3, 10, 40, 1);
		trace(1, 1, 0, 2, 3, 7);
		put_voxel(10, 10, 2, 1'b1);
		trace(0, 10, 2, 20, 10, 2);
		trace(0, 10, 2, 10, 10, 2);
		put_voxel(30, 30, 4, 1'b1);
		trace(30, 30, 4, 35, 30, 4);
		trace(30, 30, 4, 30, 30, 4);
		put_voxel(10, 10, 2, 1'b0);
		trace(20, 10, 2, 0, 10, 2);
		put_voxel(63, 63, 7, 1'b1);
		trace(63, 63, 7, 63, 0, 7);
		settle();
		program_map(7'd1, 7'd1, 7'd1);
		trace(0, 0, 0, 5, 0, 0);
		trace(5, 5, 5, 5, 5, 5);
		trace(5, 5, 5, 6, 5, 5);
		trace(0, 0, 0, 0, 0, 0);
		settle();
		program_map(7'd0, 7'd127, 7'd15);
		trace(0, 0, 0, 0, 0, 7);
		put_voxel(0, 0, 0, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			if (p == 4)
				program_map(7'($urandom_range(127)), 7'($urandom_range(127)),
					7'($urandom_range(127)));
			else
				program_map(phase_w[p], phase_h[p], phase_d[p]);
			idle_pct = phase_idle[p];
			repeat (PHASE_ITEMS) random_item();
		end

		settle();
		if (tracker.fault_count == 0 && tracker.due_points.size() == 0)
			$display("voxel_line_of_sight_tracer: match");
		else
			$display("voxel_line_of_sight_tracer: mismatch");
		$finish;
	end
endmodule
